FILE: design/mtcsp_pkg.sv
`timescale 1ns / 1ps
package mtcsp_pkg;

    localparam int CLIP_DEPTH_DEF  = 65536;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int LEN_W           = 17;
    localparam int NOTE_W          = 8;
    localparam int SMP_W           = 16;
    localparam int ADDR_W          = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int OUT_Q_DEPTH     = 4;
    localparam int CMD_Q_DEPTH     = 2;

    localparam logic [NOTE_W-1:0] KICK_NOTE_RESET  = 8'd36;
    localparam logic [NOTE_W-1:0] SNARE_NOTE_RESET = 8'd38;

    // request codes of an input item
    localparam logic [1:0] REQ_MIDI  = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KICK_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SNARE_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KICK_NOTE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SNARE_NOTE = 2'd3;

    localparam logic CLIP_KICK  = 1'b0;
    localparam logic CLIP_SNARE = 1'b1;

    typedef enum logic [1:0] {
        OP_TRIG  = 2'd0,
        OP_TICK  = 2'd1,
        OP_WRITE = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0]               req_type;
        logic                     msg_complete;
        logic [NOTE_W-1:0]        note_byte;
        logic [NOTE_W-1:0]        velocity_byte;
        logic                     write_clip;
        logic [ADDR_W-1:0]        write_addr;
        logic signed [SMP_W-1:0]  write_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [SMP_W-1:0]  sample_out;
        logic                     active;
    } t_out_item;

    typedef struct packed {
        t_op                      op;
        logic                     clip;
        logic [ADDR_W-1:0]        addr;
        logic [SMP_W-1:0]         sample;
    } t_cmd;

endpackage

FILE: design/mtcsp_ram.sv
`timescale 1ns / 1ps
module mtcsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/mtcsp_fifo.sv
`timescale 1ns / 1ps
module mtcsp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic                       i_rd,
    output logic [WIDTH-1:0]           o_rdata,
    output logic                       o_full,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_rd) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr && i_rd) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rd_ptr];
    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_rd) |-> !i_wr)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_rd)
        else $error("queue read while empty");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr && !i_rd) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count lost a write");

endmodule

FILE: design/mtcsp_front.sv
`timescale 1ns / 1ps
module mtcsp_front
    import mtcsp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_in_item          i_item,
    input  logic [NOTE_W-1:0] i_kick_note,
    input  logic [NOTE_W-1:0] i_snare_note,
    output logic              o_full,
    output logic              o_cmd_valid,
    output t_cmd              o_cmd,
    input  logic              i_cmd_take
);

    localparam int CMD_W = $bits(t_cmd);

    logic       w_accept;
    logic       w_keep;
    t_cmd       w_cmd;
    logic       w_full;
    logic       w_empty;
    logic [CMD_W-1:0] w_rdata;
    logic [$clog2(CMD_Q_DEPTH+1)-1:0] w_count;

    // classify: drop MIDI items that do not trigger and unknown requests
    always_comb begin
        w_keep       = 1'b0;
        w_cmd.op     = OP_TICK;
        w_cmd.clip   = i_item.write_clip;
        w_cmd.addr   = i_item.write_addr;
        w_cmd.sample = i_item.write_sample;
        case (i_item.req_type)
            REQ_MIDI: begin
                w_cmd.op = OP_TRIG;
                if (i_item.msg_complete && (i_item.velocity_byte != '0)) begin
                    if (i_item.note_byte == i_kick_note) begin
                        w_keep     = 1'b1;
                        w_cmd.clip = CLIP_KICK;
                    end else if (i_item.note_byte == i_snare_note) begin
                        w_keep     = 1'b1;
                        w_cmd.clip = CLIP_SNARE;
                    end
                end
            end
            REQ_TICK: begin
                w_keep   = 1'b1;
                w_cmd.op = OP_TICK;
            end
            REQ_WRITE: begin
                w_keep   = 1'b1;
                w_cmd.op = OP_WRITE;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign w_accept = i_push && !w_full;

    mtcsp_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_Q_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_accept && w_keep),
        .i_wdata (w_cmd),
        .i_rd    (i_cmd_take),
        .o_rdata (w_rdata),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_count (w_count)
    );

    assign o_full      = w_full;
    assign o_cmd_valid = !w_empty;
    assign o_cmd       = t_cmd'(w_rdata);

    a_cmd_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= ($clog2(CMD_Q_DEPTH+1))'(CMD_Q_DEPTH))
        else $error("command queue count out of range");

endmodule

FILE: design/mtcsp_back.sv
`timescale 1ns / 1ps
module mtcsp_back
    import mtcsp_pkg::*;
#(
    parameter int CLIP_DEPTH  = CLIP_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_cmd_take,
    input  logic [LEN_W-1:0] i_kick_len,
    input  logic [LEN_W-1:0] i_snare_len,
    input  logic             i_pop,
    output logic             o_empty,
    output t_out_item        o_item
);

    localparam int POS_W  = $clog2(CLIP_DEPTH);
    localparam int RAM_AW = POS_W + 1;
    localparam int RAM_D  = 2 ** RAM_AW;
    localparam int SW     = (SAMPLE_BITS < SMP_W) ? SAMPLE_BITS : SMP_W;
    localparam int CMP_W  = (POS_W + 1 > LEN_W) ? POS_W + 1 : LEN_W;
    localparam int OUT_W  = $bits(t_out_item);
    localparam int OCW    = $clog2(OUT_Q_DEPTH + 1);
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(CLIP_DEPTH);
    localparam logic [OCW:0]     OUT_CAP = (OCW+1)'(OUT_Q_DEPTH);

    // play state
    logic              r_playing, n_playing;
    logic              r_clip, n_clip;
    logic [POS_W-1:0]  r_pos, n_pos;
    // read in flight
    logic              r_rd_vld;
    logic              r_rd_hit;

    logic              w_take;
    logic              w_room;
    logic [CMP_W-1:0]  w_len;
    logic [CMP_W-1:0]  w_eff;
    logic [CMP_W-1:0]  w_pos_c;
    logic [CMP_W-1:0]  w_next_c;
    logic              w_hit;
    logic              w_issue;
    logic              w_we;
    logic [RAM_AW-1:0] w_waddr;
    logic [RAM_AW-1:0] w_raddr;
    logic [SW-1:0]     w_rdata;
    t_out_item         w_res;
    logic              w_out_full;
    logic              w_out_empty;
    logic [OCW-1:0]    w_out_cnt;
    logic [OUT_W-1:0]  w_out_data;

    // take a command only when a result slot is guaranteed
    assign w_room = ((OCW+1)'(w_out_cnt) + (OCW+1)'(r_rd_vld)) < OUT_CAP;
    assign w_take = i_cmd_valid && w_room;
    assign o_cmd_take = w_take;

    assign w_len    = CMP_W'(r_clip ? i_snare_len : i_kick_len);
    assign w_eff    = (w_len > DEPTH_C) ? DEPTH_C : w_len;
    assign w_pos_c  = CMP_W'(r_pos);
    assign w_next_c = w_pos_c + 1'b1;
    assign w_hit    = r_playing && (w_pos_c < w_eff);

    always_comb begin
        n_playing = r_playing;
        n_clip    = r_clip;
        n_pos     = r_pos;
        w_issue   = 1'b0;
        w_we      = 1'b0;
        if (w_take) begin
            case (i_cmd.op)
                OP_TRIG: begin
                    n_playing = 1'b1;
                    n_clip    = i_cmd.clip;
                    n_pos     = '0;
                end
                OP_TICK: begin
                    w_issue = 1'b1;
                    if (r_playing) begin
                        if (w_hit && (w_next_c < w_eff)) begin
                            n_pos = POS_W'(w_next_c);
                        end else begin
                            // stop and rewind
                            n_playing = 1'b0;
                            n_pos     = '0;
                        end
                    end
                end
                OP_WRITE: begin
                    w_we = (CMP_W'(i_cmd.addr) < DEPTH_C);
                end
                default: begin
                    w_issue = 1'b0;
                end
            endcase
        end
    end

    assign w_waddr = {i_cmd.clip, POS_W'(i_cmd.addr)};
    assign w_raddr = {r_clip, r_pos};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_playing <= 1'b0;
            r_clip    <= CLIP_KICK;
            r_pos     <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_hit  <= 1'b0;
        end else begin
            r_playing <= n_playing;
            r_clip    <= n_clip;
            r_pos     <= n_pos;
            r_rd_vld  <= w_issue;
            r_rd_hit  <= w_issue && w_hit;
        end
    end

    mtcsp_ram #(
        .WIDTH (SW),
        .DEPTH (RAM_D)
    ) u_clip_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_cmd.sample[SW-1:0]),
        .i_re    (w_issue && w_hit),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_res.sample_out = r_rd_hit ? SMP_W'($signed(w_rdata)) : '0;
    assign w_res.active     = r_rd_hit;

    mtcsp_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_Q_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (r_rd_vld),
        .i_wdata (w_res),
        .i_rd    (i_pop && !w_out_empty),
        .o_rdata (w_out_data),
        .o_full  (w_out_full),
        .o_empty (w_out_empty),
        .o_count (w_out_cnt)
    );

    assign o_empty = w_out_empty;
    assign o_item  = t_out_item'(w_out_data);

    a_slot_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> !w_out_full)
        else $error("result arrived with no free slot");

    a_idle_rewound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_playing |-> (r_pos == '0))
        else $error("stopped player not rewound");

    a_hit_only_when_playing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_hit |-> ($past(r_playing) && r_rd_vld))
        else $error("clip sample read while idle");

endmodule

FILE: design/midi_triggered_two_clip_sample_player.sv
`timescale 1ns / 1ps
// Two-clip drum sample player. Items enter through a queue-style port (push/full):
// a MIDI item that is complete, has a nonzero velocity and matches the kick or
// snare note restarts that clip from sample 0; a clip write item stores one
// sample; a tick item yields exactly one result (the next sample of the playing
// clip with active set, or zero with active clear otherwise). Results leave
// through a second queue-style port (empty/pop). The block sustains one item
// per clock while results are popped: a front end classifies items into a
// two-entry command queue, and a back end executes one command per clock,
// when a result slot is free, against a clip RAM with a registered read port.
// A tick's result passes through the command queue, the registered RAM read and
// the result queue. Clip RAM holds 2 * 2^ceil(log2(CLIP_DEPTH)) samples of
// min(SAMPLE_BITS, 16) bits; it is not cleared at reset, so ticks must only play
// samples that have been written. Write configuration only while no item is
// pending.
module midi_triggered_two_clip_sample_player
    import mtcsp_pkg::*;
#(
    parameter int CLIP_DEPTH  = CLIP_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input item queue
    input  logic                 push,
    output logic                 full,
    input  t_in_item             i_in,
    // result queue
    output logic                 empty,
    input  logic                 pop,
    output t_out_item            o_out,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LEN_W-1:0]     i_cfg_wdata
);

    // configuration registers
    logic [LEN_W-1:0]  r_kick_len;
    logic [LEN_W-1:0]  r_snare_len;
    logic [NOTE_W-1:0] r_kick_note;
    logic [NOTE_W-1:0] r_snare_note;

    // front to back command path
    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_cmd_take;

    // hold register values; update the one addressed by a write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kick_len   <= '0;
            r_snare_len  <= '0;
            r_kick_note  <= KICK_NOTE_RESET;
            r_snare_note <= SNARE_NOTE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KICK_LEN:   r_kick_len   <= i_cfg_wdata;
                CFG_SNARE_LEN:  r_snare_len  <= i_cfg_wdata;
                CFG_KICK_NOTE:  r_kick_note  <= i_cfg_wdata[NOTE_W-1:0];
                CFG_SNARE_NOTE: r_snare_note <= i_cfg_wdata[NOTE_W-1:0];
                default: begin
                    r_kick_len <= r_kick_len;
                end
            endcase
        end
    end

    // front: accept, classify, drop items that do nothing, queue commands
    mtcsp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_item       (i_in),
        .i_kick_note  (r_kick_note),
        .i_snare_note (r_snare_note),
        .o_full       (full),
        .o_cmd_valid  (w_cmd_valid),
        .o_cmd        (w_cmd),
        .i_cmd_take   (w_cmd_take)
    );

    // back: play state, clip RAM, result queue
    mtcsp_back #(
        .CLIP_DEPTH  (CLIP_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .i_kick_len  (r_kick_len),
        .i_snare_len (r_snare_len),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_item      (o_out)
    );

endmodule

FILE: tb/sv/tb_midi_triggered_two_clip_sample_player.sv
`timescale 1ns / 1ps
module tb_midi_triggered_two_clip_sample_player;
    import mtcsp_pkg::*;

    localparam int MEM_WORDS     = 2 * CLIP_DEPTH_DEF;
    localparam int GAP_PCT       = 23;      // chance in a hundred that a side idles
    localparam int HOLD_CYCLES   = 300;     // long receiver hold-off to fill the block
    localparam int SETTLE_CYCLES = 12;      // covers the command queue and RAM read
    localparam logic [1:0] REQ_NONE = 2'd3; // request code the block must ignore

    // Player state kept alongside the block: registers plus playback position.
    typedef struct packed {
        logic              playing;
        logic              clip;
        logic [LEN_W-1:0]  pos;
        logic [LEN_W-1:0]  kick_len;
        logic [LEN_W-1:0]  snare_len;
        logic [NOTE_W-1:0] kick_note;
        logic [NOTE_W-1:0] snare_note;
    } t_player;

    // Outcome of one item: next state, whether a result is due, and which
    // clip word it plays ({clip, position}) when it plays one.
    typedef struct packed {
        t_player          nxt;
        logic             has_res;
        logic             hit;
        logic [LEN_W-1:0] addr;
    } t_step;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 push        = 1'b0;
    logic                 full;
    t_in_item             i_in        = '0;
    logic                 empty;
    logic                 pop         = 1'b0;
    t_out_item            o_out;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [LEN_W-1:0]     i_cfg_wdata = '0;

    // Checker side: state advanced on every accepted item, clip memory image,
    // and the samples still owed by the block, oldest first.
    t_player          player;
    logic [SMP_W-1:0] clip_mem [MEM_WORDS];
    t_out_item        due_samples[$];

    // Stimulus side: a look-ahead copy of the player used while building items,
    // so that no tick ever plays a clip word that has not been written.
    t_player          plan;
    bit               written [MEM_WORDS];
    t_in_item         feed_items[$];

    bit steady    = 1'b0;   // both sides run without gaps
    bit hold_rq   = 1'b0;   // ask the receiver for one long hold-off
    bit hold_done = 1'b0;
    int hold_left = 0;
    int err_cnt   = 0;

    midi_triggered_two_clip_sample_player dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Advance the player by one item. Triggers need a complete message with a
    // nonzero velocity; the kick note is checked first, so it wins a tie.
    // A tick plays while the position is below the clamped length, and stops
    // and rewinds once the position reaches it (also when it already sits past
    // a lowered or zero length, in which case the tick is silent).
    function automatic t_step play_step(t_player p, t_in_item it);
        t_step            s;
        logic [LEN_W-1:0] len;
        s.nxt     = p;
        s.has_res = 1'b0;
        s.hit     = 1'b0;
        s.addr    = '0;
        case (it.req_type)
            REQ_MIDI: begin
                if (it.msg_complete && it.velocity_byte != '0) begin
                    if (it.note_byte == p.kick_note) begin
                        s.nxt.clip    = CLIP_KICK;
                        s.nxt.playing = 1'b1;
                        s.nxt.pos     = '0;
                    end else if (it.note_byte == p.snare_note) begin
                        s.nxt.clip    = CLIP_SNARE;
                        s.nxt.playing = 1'b1;
                        s.nxt.pos     = '0;
                    end
                end
            end
            REQ_TICK: begin
                s.has_res = 1'b1;
                if (p.playing) begin
                    len = (p.clip == CLIP_SNARE) ? p.snare_len : p.kick_len;
                    if (len > LEN_W'(CLIP_DEPTH_DEF))
                        len = LEN_W'(CLIP_DEPTH_DEF);
                    if (p.pos < len) begin
                        s.hit     = 1'b1;
                        s.addr    = {p.clip, p.pos[ADDR_W-1:0]};
                        s.nxt.pos = p.pos + 1'b1;
                    end
                    if (s.nxt.pos >= len) begin
                        s.nxt.playing = 1'b0;
                        s.nxt.pos     = '0;
                    end
                end
            end
            default: ;
        endcase
        return s;
    endfunction

    function automatic t_player with_reg(t_player p, logic [CFG_IDX_W-1:0] idx,
                                         logic [LEN_W-1:0] v);
        case (idx)
            CFG_KICK_LEN:   p.kick_len   = v;
            CFG_SNARE_LEN:  p.snare_len  = v;
            CFG_KICK_NOTE:  p.kick_note  = v[NOTE_W-1:0];
            CFG_SNARE_NOTE: p.snare_note = v[NOTE_W-1:0];
            default: ;
        endcase
        return p;
    endfunction

    // Fully random item; callers override the fields that matter, the rest
    // stays random so every bit of every field toggles.
    function automatic t_in_item rand_item();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[$bits(t_in_item)-1:0];
    endfunction

    // Append one item to the feed. If it is a tick that would play a word
    // never written, store a random sample there first.
    task automatic queue_item(input t_in_item it);
        t_step    s;
        t_in_item fill;
        s = play_step(plan, it);
        if (s.hit && !written[s.addr]) begin
            fill            = rand_item();
            fill.req_type   = REQ_WRITE;
            fill.write_clip = s.addr[ADDR_W];
            fill.write_addr = s.addr[ADDR_W-1:0];
            written[s.addr] = 1'b1;
            feed_items.push_back(fill);
        end
        if (it.req_type == REQ_WRITE)
            written[{it.write_clip, it.write_addr}] = 1'b1;
        plan = s.nxt;
        feed_items.push_back(it);
    endtask

    task automatic add_midi(input logic [NOTE_W-1:0] note, input logic [NOTE_W-1:0] vel,
                            input logic complete);
        t_in_item it;
        it               = rand_item();
        it.req_type      = REQ_MIDI;
        it.note_byte     = note;
        it.velocity_byte = vel;
        it.msg_complete  = complete;
        queue_item(it);
    endtask

    task automatic add_ticks(input int n);
        t_in_item it;
        repeat (n) begin
            it          = rand_item();
            it.req_type = REQ_TICK;
            queue_item(it);
        end
    endtask

    task automatic add_write(input logic clip, input logic [ADDR_W-1:0] addr,
                             input logic [SMP_W-1:0] smp);
        t_in_item it;
        it              = rand_item();
        it.req_type     = REQ_WRITE;
        it.write_clip   = clip;
        it.write_addr   = addr;
        it.write_sample = smp;
        queue_item(it);
    endtask

    // Random traffic: mostly ticks and triggers on the configured notes, so
    // the clips actually play, with stray notes, incomplete or silent
    // messages, writes over the played region and unknown requests mixed in.
    task automatic queue_random(input int n);
        t_in_item it;
        int       pick;
        repeat (n) begin
            it   = rand_item();
            pick = $urandom_range(99);
            if (pick < 45) begin
                it.req_type = REQ_TICK;
            end else if (pick < 70) begin
                it.req_type     = REQ_MIDI;
                it.msg_complete = ($urandom_range(9) != 0);
                case ($urandom_range(3))
                    0: it.note_byte = plan.kick_note;
                    1: it.note_byte = plan.snare_note;
                    default: ;
                endcase
                if ($urandom_range(9) == 0)
                    it.velocity_byte = '0;
            end else if (pick < 95) begin
                it.req_type = REQ_WRITE;
                if ($urandom_range(3) != 0)
                    it.write_addr = ADDR_W'($urandom_range(31));
            end else begin
                it.req_type = REQ_NONE;
            end
            queue_item(it);
        end
    endtask

    // Write one register at a rising edge and mirror it into both copies.
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value[LEN_W-1:0];
        player = with_reg(player, idx, value[LEN_W-1:0]);
        plan   = with_reg(plan, idx, value[LEN_W-1:0]);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure(input int unsigned kick_len, input int unsigned snare_len,
                             input int unsigned kick_note, input int unsigned snare_note);
        set_reg(CFG_KICK_LEN, kick_len);
        set_reg(CFG_SNARE_LEN, snare_len);
        set_reg(CFG_KICK_NOTE, kick_note);
        set_reg(CFG_SNARE_NOTE, snare_note);
    endtask

    // Poll at the falling edge, clear of the clocked processes. Items that give
    // no result may still sit in the command queue when the last sample lands,
    // so wait for the settle period before touching the registers.
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (feed_items.size() != 0 || push || due_samples.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Driver: hold an offered item until accepted, predict its outcome at the
    // accepting edge, then offer the next one or idle at random.
    always @(posedge i_clk) begin : drive_blk
        t_step     s;
        t_out_item owed;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                s = play_step(player, i_in);
                if (i_in.req_type == REQ_WRITE)
                    clip_mem[{i_in.write_clip, i_in.write_addr}] = i_in.write_sample;
                if (s.has_res) begin
                    owed.sample_out = s.hit ? clip_mem[s.addr] : '0;
                    owed.active     = s.hit;
                    due_samples.push_back(owed);
                end
                player = s.nxt;
            end
            if (!push || !full) begin
                if (feed_items.size() != 0 && (steady || $urandom_range(99) >= GAP_PCT)) begin
                    push <= 1'b1;
                    i_in <= feed_items.pop_front();
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each popped result with the oldest owed sample, then
    // decide whether to pop next cycle. One long hold-off, counted here, lets
    // the block fill up and push back on the sender.
    always @(posedge i_clk) begin : watch_blk
        t_out_item want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (due_samples.size() == 0) begin
                    $display("%0t: result with none owed: sample_out %0d active %0b",
                             $time, o_out.sample_out, o_out.active);
                    err_cnt++;
                end else begin
                    want = due_samples.pop_front();
                    if (o_out.sample_out !== want.sample_out) begin
                        $display("%0t: sample_out expected %0d actual %0d",
                                 $time, want.sample_out, o_out.sample_out);
                        err_cnt++;
                    end
                    if (o_out.active !== want.active) begin
                        $display("%0t: active expected %0b actual %0b",
                                 $time, want.active, o_out.active);
                        err_cnt++;
                    end
                end
            end
            if (hold_rq && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left != 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= steady || ($urandom_range(99) >= GAP_PCT);
            end
        end
    end

    initial begin : main_blk
        player = '{playing: 1'b0, clip: CLIP_KICK, pos: '0, kick_len: '0, snare_len: '0,
                   kick_note: KICK_NOTE_RESET, snare_note: SNARE_NOTE_RESET};
        plan   = player;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: short clips on the reset notes.
        configure(4, 2, KICK_NOTE_RESET, SNARE_NOTE_RESET);
        add_ticks(1);                                   // idle tick gives silence
        add_write(CLIP_KICK, 16'd0, 16'sh8000);         // sample extremes
        add_write(CLIP_KICK, 16'd1, 16'sh7FFF);
        add_write(CLIP_KICK, 16'd2, 16'sh0000);
        add_write(CLIP_KICK, 16'd3, 16'shFFFF);
        add_midi(KICK_NOTE_RESET, 8'd100, 1'b0);        // incomplete message: drop
        add_midi(KICK_NOTE_RESET, 8'd0, 1'b1);          // zero velocity: drop
        add_ticks(1);
        add_midi(KICK_NOTE_RESET, 8'd255, 1'b1);
        add_ticks(2);
        add_midi(SNARE_NOTE_RESET, 8'd1, 1'b1);         // retrigger onto the other clip
        add_ticks(3);                                   // both snare samples, then silence
        begin : odd_req
            t_in_item it;
            it          = rand_item();
            it.req_type = REQ_NONE;
            queue_item(it);
        end
        add_midi(KICK_NOTE_RESET, 8'd127, 1'b1);
        add_ticks(5);                                   // whole kick clip plus one
        add_write(CLIP_SNARE, 16'hFFFF, 16'sh7FFF);     // top address of each clip
        add_write(CLIP_KICK, 16'hFFFF, 16'sh8000);
        wait_drained();

        // Random, then leave the kick clip playing mid-way into the next phase.
        configure(20, 12, KICK_NOTE_RESET, SNARE_NOTE_RESET);
        queue_random(150);
        add_midi(KICK_NOTE_RESET, 8'd64, 1'b1);
        add_ticks(8);
        wait_drained();

        // Kick length lowered below the live position; zero-length snare.
        configure(3, 0, 255, 0);
        add_ticks(1);
        add_midi(8'd0, 8'd90, 1'b1);
        add_ticks(1);
        queue_random(150);
        wait_drained();

        // Lengths at and beyond the clip depth; both notes equal, kick wins.
        configure(131071, 65536, 60, 60);
        add_midi(8'd60, 8'd100, 1'b1);
        add_ticks(3);
        queue_random(150);
        wait_drained();

        // Receiver holds off while the sender keeps offering items.
        hold_rq = 1'b1;
        configure(7, 5, 0, 255);
        queue_random(200);
        wait_drained();

        // Both sides at full rate.
        steady = 1'b1;
        configure(1, 65535, KICK_NOTE_RESET, SNARE_NOTE_RESET);
        queue_random(200);
        wait_drained();

        if (err_cnt == 0 && due_samples.size() == 0) begin
            $display("** midi_triggered_two_clip_sample_player: PASSED **");
        end else begin
            if (due_samples.size() != 0)
                $display("%0t: %0d results never arrived", $time, due_samples.size());
            $display("** midi_triggered_two_clip_sample_player: FAILED **");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #200000;
        $display("%0t: timeout, %0d items unsent, %0d results owed",
                 $time, feed_items.size(), due_samples.size());
        $display("** midi_triggered_two_clip_sample_player: FAILED **");
        $finish;
    end

endmodule
